[src/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the sample statistics block
// Field widths, status codes, channel id reset values and the per-slot
// statistics record.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SQ_W       = 2 * SAMPLE_W;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned SUM_W      = 44;
  localparam int unsigned SUMSQ_W    = 56;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 2;

  // Channel id registers on the configuration port
  localparam int unsigned ID_REGS   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = CODE_W;

  localparam logic [ID_REGS-1:0][CODE_W-1:0] ID_RESET = {4'd6, 4'd3, 4'd0};

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 2'd0,
    ST_NO_MATCH  = 2'd1,
    ST_SATURATED = 2'd2,
    ST_CLEARED   = 2'd3
  } status_e;

  // Interval statistics of one slot
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    total;
    logic [SUMSQ_W-1:0]  total_squares;
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] highest;
    logic [SAMPLE_W-1:0] latest;
  } slot_stat_t;

endpackage

[src/mss_match.sv]
// ----------------------------------------------------------------------------
// mss_match: channel code to slot lookup
// Compares the code with every configured channel id; the lowest matching
// slot wins. Slots without an id register never match.
// ----------------------------------------------------------------------------
module mss_match
  import mss_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 3,
  parameter int unsigned SLOT_W    = 2
) (
  input  logic [ID_REGS-1:0][CODE_W-1:0] ids_i,
  input  logic [CODE_W-1:0]              code_i,
  output logic                           hit_o,
  output logic [SLOT_W-1:0]              idx_o
);

  localparam int unsigned NUM_IDS = (NUM_SLOTS < ID_REGS) ? NUM_SLOTS : ID_REGS;

  // Priority search, walked from the top so the lowest slot ends up winning
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (ids_i[i] == code_i) begin
        hit_o = 1'b1;
        idx_o = SLOT_W'(i);
      end
    end
  end

endmodule

[src/mss_slot.sv]
// ----------------------------------------------------------------------------
// mss_slot: statistics registers of one slot
// Holds count, sums, min, max and last sample, and gives the record
// as it will be after this cycle's update or clear.
// ----------------------------------------------------------------------------
module mss_slot
  import mss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                upd_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SQ_W-1:0]     sample_sq_i,
  output logic                sat_o,
  output slot_stat_t          stat_next_o
);

  slot_stat_t stat_q, stat_d;

  // Count saturated: further samples are dropped
  assign sat_o = &stat_q.count;

  // Next record
  always_comb begin
    stat_d = stat_q;
    if (clear_i) begin
      stat_d.count         = '0;
      stat_d.total         = '0;
      stat_d.total_squares = '0;
      stat_d.lowest        = SAMPLE_MAX;
      stat_d.highest       = '0;
    end else if (upd_i) begin
      stat_d.count         = stat_q.count + COUNT_W'(1);
      stat_d.total         = stat_q.total + SUM_W'(sample_i);
      stat_d.total_squares = stat_q.total_squares + SUMSQ_W'(sample_sq_i);
      if (sample_i < stat_q.lowest) begin
        stat_d.lowest = sample_i;
      end
      if (sample_i > stat_q.highest) begin
        stat_d.highest = sample_i;
      end
      stat_d.latest = sample_i;
    end
  end

  assign stat_next_o = stat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q.count         <= '0;
      stat_q.total         <= '0;
      stat_q.total_squares <= '0;
      stat_q.lowest        <= SAMPLE_MAX;
      stat_q.highest       <= '0;
      stat_q.latest        <= '0;
    end else begin
      stat_q <= stat_d;
    end
  end

endmodule

[src/multichannel_sample_statistics.sv]
// ----------------------------------------------------------------------------
// multichannel_sample_statistics: per-channel running statistics
// Pipeline: an item transfer loads the input register, and the item moves on into the
//   result register once it frees up. Throughput: one item per cycle unless the output stalls.
// The slot state is written in the same cycle the item leaves the input
//   register, so the next item always sees the updated slot.
// Reset: all slots empty (min 4095), ids 0/3/6, both stages empty.
// ----------------------------------------------------------------------------
module multichannel_sample_statistics
  import mss_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  // item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [CODE_W-1:0]     channel_code_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic [COUNT_W-1:0]    count_o,
  output logic [SUM_W-1:0]      total_o,
  output logic [SUMSQ_W-1:0]    total_squares_o,
  output logic [SAMPLE_W-1:0]   lowest_o,
  output logic [SAMPLE_W-1:0]   highest_o,
  output logic [SAMPLE_W-1:0]   latest_o
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Channel id registers
  logic [ID_REGS-1:0][CODE_W-1:0] ids_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_q <= ID_RESET;
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(ID_REGS))) begin
      ids_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Handshake: input stage moves on whenever the result register frees up
  logic in_xfer, s1_adv;
  logic s1_valid_q, out_valid_q;

  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register; the square is formed on the way in
  logic                mode_q;
  logic [CODE_W-1:0]   code_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SQ_W-1:0]     sample_sq_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q      <= mode_i;
      code_q      <= channel_code_i;
      sample_q    <= sample_i;
      sample_sq_q <= SQ_W'(sample_i) * SQ_W'(sample_i);
    end
  end

  // Slot lookup
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;

  mss_match #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_match (
    .ids_i  (ids_q),
    .code_i (code_q),
    .hit_o  (hit),
    .idx_o  (hit_idx)
  );

  // Slot state
  logic                 clear;
  logic [NUM_SLOTS-1:0] sat;
  logic [NUM_SLOTS-1:0] upd;
  slot_stat_t           stat_next [NUM_SLOTS];

  assign clear = s1_adv && mode_q;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    assign upd[g] = s1_adv && !mode_q && hit && (hit_idx == SLOT_W'(g)) && !sat[g];

    mss_slot u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clear_i     (clear),
      .upd_i       (upd[g]),
      .sample_i    (sample_q),
      .sample_sq_i (sample_sq_q),
      .sat_o       (sat[g]),
      .stat_next_o (stat_next[g])
    );
  end

  // Result formation
  status_e                 status_d, status_q;
  logic [SLOT_OUT_W-1:0]   slot_d, slot_q;
  slot_stat_t              res_d, res_q;

  always_comb begin
    status_d = ST_NO_MATCH;
    slot_d   = '0;
    res_d    = '0;
    if (mode_q) begin
      status_d = ST_CLEARED;
    end else if (hit) begin
      status_d = sat[hit_idx] ? ST_SATURATED : ST_UPDATED;
      slot_d   = SLOT_OUT_W'(hit_idx);
      res_d    = stat_next[hit_idx];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      res_q    <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign count_o         = res_q.count;
  assign total_o         = res_q.total;
  assign total_squares_o = res_q.total_squares;
  assign lowest_o        = res_q.lowest;
  assign highest_o       = res_q.highest;
  assign latest_o        = res_q.latest;

endmodule

[src/mss_checker.sv]
// ----------------------------------------------------------------------------
// mss_checker: port-level checks for the sample statistics block
// Watches the result channel and checks the shape of each result record.
// ----------------------------------------------------------------------------
module mss_checker
  import mss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic [STATUS_W-1:0]   status_o,
  input  logic [SLOT_OUT_W-1:0] slot_o,
  input  logic [COUNT_W-1:0]    count_o,
  input  logic [SUM_W-1:0]      total_o,
  input  logic [SUMSQ_W-1:0]    total_squares_o,
  input  logic [SAMPLE_W-1:0]   lowest_o,
  input  logic [SAMPLE_W-1:0]   highest_o,
  input  logic [SAMPLE_W-1:0]   latest_o
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_o) && $stable(status_o))
    else $error("stalled result dropped or changed");

  // Clear and no-match results carry an empty record
  a_empty_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CLEARED || status_o == ST_NO_MATCH)
      |-> slot_o == '0 && count_o == '0 && total_o == '0 && total_squares_o == '0
          && lowest_o == '0 && highest_o == '0 && latest_o == '0)
    else $error("clear or no-match result not empty");

  // An updated slot holds at least the sample just taken
  a_upd_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UPDATED
      |-> count_o != '0 && lowest_o <= latest_o && latest_o <= highest_o
          && total_o >= SUM_W'(latest_o))
    else $error("updated record inconsistent");

  // A saturated result reports a full count
  a_sat_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SATURATED |-> &count_o)
    else $error("saturated result without full count");

  // Only slots with an id register can be reported
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_o < SLOT_OUT_W'(ID_REGS))
    else $error("slot index out of range");

endmodule

bind multichannel_sample_statistics mss_checker u_mss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .slot_o          (slot_o),
  .count_o         (count_o),
  .total_o         (total_o),
  .total_squares_o (total_squares_o),
  .lowest_o        (lowest_o),
  .highest_o       (highest_o),
  .latest_o        (latest_o)
);
